// ===== design/crci_pkg.sv =====
package crci_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 10;

  localparam int unsigned TSTEP_W      = 11;
  localparam logic [TSTEP_W-1:0] TSTEP_RST = 11'd102;

  localparam int unsigned POINT_W = 16;
  localparam int unsigned CURVE_W = 18;
  localparam int unsigned SEG_W   = 16;
  localparam int unsigned TFRAC_W = 10;
  localparam int CURVE_MAX = 131071;
  localparam int CURVE_MIN = -131072;

  typedef struct packed {
    logic signed [POINT_W-1:0] point_value;
    logic                      curve_start;
  } crci_in_t;

  typedef struct packed {
    logic signed [CURVE_W-1:0] curve_value;
    logic [SEG_W-1:0]          segment_index;
    logic [TFRAC_W-1:0]        t_frac;
    logic                      last_of_run;
  } crci_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CUBE,
    ST_WGT,
    ST_MAC,
    ST_SUM,
    ST_EMIT
  } crci_state_e;

  typedef enum logic [1:0] {
    MUL_W_P,
    MUL_T_T,
    MUL_T2_T
  } crci_mul_sel_e;

  typedef struct packed {
    logic in_valid;
    logic win_full;
    logic last;
    logic out_free;
  } crci_stat_t;

  typedef struct packed {
    logic          in_ready;
    crci_mul_sel_e mul_sel;
    logic [1:0]    tap;
    logic          t2_load;
    logic          wgt_load;
    logic          acc_clr;
    logic          acc_add;
    logic          emit;
    logic          t_adv;
    logic          run_done;
  } crci_ctrl_t;

endpackage

// ===== design/crci_mul.sv =====
module crci_mul #(
  parameter int unsigned A_W = 21,
  parameter int unsigned B_W = 16
) (
  input  logic                       clk_i,
  input  logic signed [A_W-1:0]      a_i,
  input  logic signed [B_W-1:0]      b_i,
  output logic signed [A_W+B_W-1:0]  p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  // Product is registered so the next consumer starts from a clean flop.
  always_ff @(posedge clk_i) begin
    p_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== design/crci_seq.sv =====
module crci_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  crci_pkg::crci_stat_t   stat_i,
  output crci_pkg::crci_ctrl_t   ctrl_o
);
  import crci_pkg::*;

  crci_state_e state_q, state_d;
  logic [1:0]  tap_q, tap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

  always_comb begin
    state_d = state_q;
    tap_d   = 2'd0;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid && stat_i.win_full) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ:   state_d = ST_CUBE;
      ST_CUBE: state_d = ST_WGT;
      ST_WGT:  state_d = ST_MAC;
      ST_MAC: begin
        tap_d = tap_q + 2'd1;
        if (tap_q == 2'd3) begin
          state_d = ST_SUM;
          tap_d   = 2'd0;
        end
      end
      ST_SUM:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = stat_i.last ? ST_IDLE : ST_SQ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_sel = MUL_W_P;
    ctrl_o.tap     = tap_q;
    unique case (state_q)
      ST_IDLE: ctrl_o.in_ready = 1'b1;
      ST_SQ:   ctrl_o.mul_sel = MUL_T_T;
      ST_CUBE: begin
        ctrl_o.mul_sel = MUL_T2_T;
        ctrl_o.t2_load = 1'b1;
      end
      ST_WGT:  ctrl_o.wgt_load = 1'b1;
      ST_MAC: begin
        // The product issued in the weight cycle is junk, so the first tap clears.
        ctrl_o.acc_clr = (tap_q == 2'd0);
        ctrl_o.acc_add = (tap_q != 2'd0);
      end
      ST_SUM:  ctrl_o.acc_add = 1'b1;
      ST_EMIT: begin
        ctrl_o.emit     = stat_i.out_free;
        ctrl_o.t_adv    = stat_i.out_free && !stat_i.last;
        ctrl_o.run_done = stat_i.out_free && stat_i.last;
      end
      default: ctrl_o.in_ready = 1'b0;
    endcase
  end

endmodule

// ===== design/catmull_rom_curve_interpolator.sv =====
// Catmull-Rom curve interpolator.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one control point per beat,
// with curve_start set on the first point of a new curve. Output channel
// (out_valid_o/out_ready_i, out_data_o) carries interpolated samples of the segment
// between the two middle points of the last four, t stepping from 0 by t_step.
// cfg_we_i writes t_step from cfg_wdata_i; write it only while the block is idle.
// A point that does not complete the four-point window is accepted and gives no
// output. A point that does gives N = ceil(2^FRAC_BITS / max(t_step, 2^FRAC_BITS/32))
// samples, at most 32. Every sample runs on the one shared multiplier in these steps:
// t*t, t^2*t, weight forming, four weight-by-point products and an accumulate drain,
// then the load into the output register. After such a point is accepted, in_ready_o
// stays low until its last sample is loaded into the output register.
// The output register lets the next point be accepted while the last sample waits.
// When the receiver stalls, the sequencer holds in its emit cycle until the output
// register frees up. Reset clears the window and segment count, and sets t_step to 102.
module catmull_rom_curve_interpolator #(
  parameter int unsigned SAMPLE_BITS = crci_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = crci_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  crci_pkg::crci_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output crci_pkg::crci_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [crci_pkg::TSTEP_W-1:0]        cfg_wdata_i
);
  import crci_pkg::*;

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned TW   = ((F > TSTEP_W) ? F : TSTEP_W) + 1;
  localparam int unsigned WW   = F + 10;
  localparam int unsigned MA   = (2*F + 1 > WW) ? 2*F + 1 : WW;
  localparam int unsigned MB   = (F + 1 > SAMPLE_BITS) ? F + 1 : SAMPLE_BITS;
  localparam int unsigned PW   = MA + MB;
  localparam int unsigned RW   = 3*F + 4;
  localparam int unsigned AW   = WW + SAMPLE_BITS + 2;
  localparam int unsigned WSH  = 2*F - 7;
  localparam int unsigned ASH  = F + 8;
  localparam int unsigned MIN_STEP = ((1 << F) + 31) / 32;

  localparam logic [TW-1:0]        ONE_T    = TW'(1) << F;
  localparam logic [TW-1:0]        MIN_T    = TW'(MIN_STEP);
  localparam logic signed [RW-1:0] S3X2     = RW'(1) << (3*F + 1);
  localparam logic signed [RW-1:0] WRND     = RW'(1) << (WSH - 1);
  localparam logic signed [AW-1:0] ARND     = AW'(1) << (ASH - 1);
  localparam logic signed [AW-1:0] OUT_MAX  = AW'(CURVE_MAX);
  localparam logic signed [AW-1:0] OUT_MIN  = AW'(CURVE_MIN);

  crci_ctrl_t ctrl;
  crci_stat_t stat;

  logic [TSTEP_W-1:0]            t_step_q;
  logic signed [SAMPLE_BITS-1:0] win_q [4];
  logic [1:0]                    fill_q;
  logic [SEG_W-1:0]              seg_q;
  logic [TW-1:0]                 t_q;
  logic [2*F-1:0]                t2_q;
  logic signed [WW-1:0]          w_q [4];
  logic signed [AW-1:0]          acc_q;
  crci_out_t                     out_q;
  logic                          out_valid_q;

  logic                          in_take;
  logic [TW-1:0]                 step_eff;
  logic [TW-1:0]                 t_next;
  logic signed [SAMPLE_BITS-1:0] pt_new;
  logic signed [MA-1:0]          mul_a;
  logic signed [MB-1:0]          mul_b;
  logic signed [PW-1:0]          prod;
  logic signed [RW-1:0]          t3w, t2s, ts2;
  logic signed [RW-1:0]          raw [4];
  logic signed [RW-1:0]          wr [4];
  logic signed [AW-1:0]          acc_rnd, acc_sh, sat;

  assign in_take  = in_valid_i && ctrl.in_ready;
  assign step_eff = (TW'(t_step_q) < MIN_T) ? MIN_T : TW'(t_step_q);
  assign t_next   = t_q + step_eff;
  assign pt_new   = SAMPLE_BITS'(unsigned'(in_data_i.point_value));

  assign stat.in_valid = in_valid_i;
  assign stat.win_full = !in_data_i.curve_start && (fill_q == 2'd3);
  assign stat.last     = (t_next >= ONE_T);
  assign stat.out_free = !out_valid_q || out_ready_i;

  crci_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_T_T: begin
        mul_a = MA'(t_q[F-1:0]);
        mul_b = MB'(t_q[F-1:0]);
      end
      MUL_T2_T: begin
        mul_a = MA'(prod[2*F-1:0]);
        mul_b = MB'(t_q[F-1:0]);
      end
      MUL_W_P: begin
        mul_a = MA'(w_q[ctrl.tap]);
        mul_b = MB'(win_q[ctrl.tap]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  crci_mul #(
    .A_W (MA),
    .B_W (MB)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Doubled weights scaled by 2^(3F); t^3 sits in the multiplier output this cycle.
  always_comb begin
    t3w    = RW'(prod[3*F-1:0]);
    t2s    = RW'(t2_q) << F;
    ts2    = RW'(t_q[F-1:0]) << (2*F);
    raw[0] = (t2s <<< 1) - t3w - ts2;
    raw[1] = (t3w <<< 1) + t3w - (t2s <<< 2) - t2s + S3X2;
    raw[2] = (t2s <<< 2) + ts2 - (t3w <<< 1) - t3w;
    raw[3] = t3w - t2s;
    for (int k = 0; k < 4; k++) begin
      wr[k] = raw[k] + WRND;
    end
  end

  always_comb begin
    acc_rnd = acc_q + ARND;
    acc_sh  = acc_rnd >>> ASH;
    if (acc_sh > OUT_MAX) begin
      sat = OUT_MAX;
    end else if (acc_sh < OUT_MIN) begin
      sat = OUT_MIN;
    end else begin
      sat = acc_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_step_q <= TSTEP_RST;
    end else if (cfg_we_i) begin
      t_step_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        win_q[k] <= '0;
      end
      fill_q <= 2'd0;
      seg_q  <= '0;
      t_q    <= '0;
    end else begin
      if (in_take) begin
        // A start beat flushes the window, so only the new point survives.
        for (int k = 0; k < 3; k++) begin
          win_q[k] <= in_data_i.curve_start ? '0 : win_q[k+1];
        end
        win_q[3] <= pt_new;
        if (in_data_i.curve_start) begin
          fill_q <= 2'd1;
          seg_q  <= '0;
        end else if (fill_q != 2'd3) begin
          fill_q <= fill_q + 2'd1;
        end
        t_q <= '0;
      end
      if (ctrl.t_adv) begin
        t_q <= t_next;
      end
      if (ctrl.run_done) begin
        seg_q <= seg_q + SEG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.t2_load) begin
      t2_q <= prod[2*F-1:0];
    end
    if (ctrl.wgt_load) begin
      for (int k = 0; k < 4; k++) begin
        w_q[k] <= wr[k][WSH +: WW];
      end
    end
    if (ctrl.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl.acc_add) begin
      acc_q <= acc_q + AW'(prod);
    end
    if (ctrl.emit) begin
      out_q.curve_value   <= sat[CURVE_W-1:0];
      out_q.segment_index <= seg_q + SEG_W'(1);
      out_q.t_frac        <= TFRAC_W'(t_q);
      out_q.last_of_run   <= stat.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> (!out_valid_q || out_ready_i))
    else $error("sample loaded over an unaccepted output beat");

  a_t_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.mul_sel == MUL_T_T) |-> (t_q < ONE_T))
    else $error("t reached one inside a segment");

  a_busy_after_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && stat.win_full) |=> !in_ready_o)
    else $error("input taken while a segment is being produced");

endmodule
